### sv/point_step_along_segment_top_assert.svh
// Assertion macros for the point stepping block.
`ifndef POINT_STEP_ALONG_SEGMENT_TOP_ASSERT_SVH
`define POINT_STEP_ALONG_SEGMENT_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pss_pkg.sv
// Shared constants for the point stepping block.
package pss_pkg;
  localparam int COORD_BITS_DEF     = 16;
  localparam int DIST_FRAC_BITS_DEF = 8;
  localparam int DIST_BITS          = 24;
endpackage

### sv/pss_in_if.sv
// Input channel: previous point, current point and step distance.
interface pss_in_if #(
  parameter int COORD_BITS = pss_pkg::COORD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS-1:0]   last_x;
  logic signed [COORD_BITS-1:0]   last_y;
  logic signed [COORD_BITS-1:0]   cur_x;
  logic signed [COORD_BITS-1:0]   cur_y;
  logic [pss_pkg::DIST_BITS-1:0]  step_distance;

  modport source (output valid, last_x, last_y, cur_x, cur_y, step_distance, input ready);
  modport sink   (input valid, last_x, last_y, cur_x, cur_y, step_distance, output ready);
endinterface

### sv/pss_out_if.sv
// Output channel: stepped point.
interface pss_out_if #(
  parameter int COORD_BITS = pss_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] new_x;
  logic signed [COORD_BITS-1:0] new_y;

  modport source (output valid, new_x, new_y, input ready);
  modport sink   (input valid, new_x, new_y, output ready);
endinterface

### sv/point_step_along_segment_top.sv
// Steps from last toward cur by step_distance (fixed point, DIST_FRAC_BITS
// fraction bits) and returns the point truncated toward zero and saturated.
// Fully pipelined: one transaction per cycle while the output is not
// stalled. The integer root search resolves one result bit per stage. A
// stall at the output holds the whole pipeline. Exact integer arithmetic,
// no rounding error.
module point_step_along_segment_top #(
  parameter int COORD_BITS     = pss_pkg::COORD_BITS_DEF,
  parameter int DIST_FRAC_BITS = pss_pkg::DIST_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  pss_in_if.sink    in_ch,
  pss_out_if.source out_ch
);
  import pss_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FB = DIST_FRAC_BITS;
  localparam int DW = DIST_BITS;
  localparam int MB = DW - FB;           // integer bits of the step
  localparam int SW = 2 * CB + 1;        // dx^2 + dy^2
  localparam int NW = DW + CB;           // dist * |delta|
  localparam int LW = NW / 2;
  localparam int HW = NW - LW;
  localparam int EW = 2 * NW;
  localparam int WW = EW + 2;            // root search datapath
  localparam int VW = ((CB > MB) ? CB : MB) + 2;
  localparam int NS = MB + 5;            // valid bits

  localparam logic signed [VW-1:0] MAXV = {{(VW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [VW-1:0] MINV = ~MAXV;

  typedef struct packed {
    logic [CB-1:0]        ax;
    logic [CB-1:0]        ay;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] lx;
    logic signed [CB-1:0] ly;
    logic [DW-1:0]        step_len;
  } p1_t;

  typedef struct packed {
    logic [2*CB-1:0]      sx;
    logic [2*CB-1:0]      sy;
    logic [NW-1:0]        nx;
    logic [NW-1:0]        ny;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] lx;
    logic signed [CB-1:0] ly;
  } p2_t;

  typedef struct packed {
    logic [SW-1:0]        s;
    logic [2*HW-1:0]      hhx;
    logic [NW-1:0]        hlx;
    logic [2*LW-1:0]      llx;
    logic [2*HW-1:0]      hhy;
    logic [NW-1:0]        hly;
    logic [2*LW-1:0]      lly;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] lx;
    logic signed [CB-1:0] ly;
  } p3_t;

  typedef struct packed {
    logic [WW-1:0]        k;
    logic [WW-1:0]        ex;
    logic [WW-1:0]        yx;
    logic [MB-1:0]        mx;
    logic [WW-1:0]        ey;
    logic [WW-1:0]        yy;
    logic [MB-1:0]        my;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] lx;
    logic signed [CB-1:0] ly;
  } it_t;

  logic [NS-1:0] vld;
  logic          en;
  p1_t           p1, p1_next;
  p2_t           p2, p2_next;
  p3_t           p3, p3_next;
  it_t           it [MB+1];
  it_t           it0_next;
  logic signed [CB-1:0] new_x, new_y, new_x_next, new_y_next;

  assign en           = !vld[NS-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld[NS-1];
  assign out_ch.new_x = new_x;
  assign out_ch.new_y = new_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_ch.valid};
    end
  end

  // Deltas and magnitudes; equal points step toward -y.
  always_comb begin
    logic signed [CB:0] dx, dy, ndx, ndy;
    dx = {in_ch.cur_x[CB-1], in_ch.cur_x} - {in_ch.last_x[CB-1], in_ch.last_x};
    dy = {in_ch.cur_y[CB-1], in_ch.cur_y} - {in_ch.last_y[CB-1], in_ch.last_y};
    if (dx == '0 && dy == '0) begin
      dy = '1;
    end
    ndx = -dx;
    ndy = -dy;
    p1_next.negx     = dx[CB];
    p1_next.negy     = dy[CB];
    p1_next.ax       = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
    p1_next.ay       = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
    p1_next.lx       = in_ch.last_x;
    p1_next.ly       = in_ch.last_y;
    p1_next.step_len = in_ch.step_distance;
  end

  always_comb begin
    p2_next.sx   = (2*CB)'(p1.ax) * (2*CB)'(p1.ax);
    p2_next.sy   = (2*CB)'(p1.ay) * (2*CB)'(p1.ay);
    p2_next.nx   = NW'(p1.step_len) * NW'(p1.ax);
    p2_next.ny   = NW'(p1.step_len) * NW'(p1.ay);
    p2_next.negx = p1.negx;
    p2_next.negy = p1.negy;
    p2_next.lx   = p1.lx;
    p2_next.ly   = p1.ly;
  end

  // Squared length, and square of the numerator in partial products.
  always_comb begin
    p3_next.s    = SW'(p2.sx) + SW'(p2.sy);
    p3_next.hhx  = (2*HW)'(p2.nx[NW-1:LW]) * (2*HW)'(p2.nx[NW-1:LW]);
    p3_next.hlx  = NW'(p2.nx[NW-1:LW]) * NW'(p2.nx[LW-1:0]);
    p3_next.llx  = (2*LW)'(p2.nx[LW-1:0]) * (2*LW)'(p2.nx[LW-1:0]);
    p3_next.hhy  = (2*HW)'(p2.ny[NW-1:LW]) * (2*HW)'(p2.ny[NW-1:LW]);
    p3_next.hly  = NW'(p2.ny[NW-1:LW]) * NW'(p2.ny[LW-1:0]);
    p3_next.lly  = (2*LW)'(p2.ny[LW-1:0]) * (2*LW)'(p2.ny[LW-1:0]);
    p3_next.negx = p2.negx;
    p3_next.negy = p2.negy;
    p3_next.lx   = p2.lx;
    p3_next.ly   = p2.ly;
  end

  always_comb begin
    it0_next.k    = WW'(p3.s) << (2 * FB);
    it0_next.ex   = (WW'(p3.hhx) << (2 * LW)) + (WW'(p3.hlx) << (LW + 1)) + WW'(p3.llx);
    it0_next.ey   = (WW'(p3.hhy) << (2 * LW)) + (WW'(p3.hly) << (LW + 1)) + WW'(p3.lly);
    it0_next.yx   = '0;
    it0_next.yy   = '0;
    it0_next.mx   = '0;
    it0_next.my   = '0;
    it0_next.negx = p3.negx;
    it0_next.negy = p3.negy;
    it0_next.lx   = p3.lx;
    it0_next.ly   = p3.ly;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= p1_next;
      p2    <= p2_next;
      p3    <= p3_next;
      it[0] <= it0_next;
    end
  end

  // Root search: E = N^2 - K*m^2 and Y = K*m kept as running values,
  // one bit of m per stage.
  for (genvar j = 0; j < MB; j++) begin : g_root
    localparam int B = MB - 1 - j;
    it_t nxt;

    always_comb begin
      logic [WW-1:0] tx, ty;
      logic [WW:0]   dfx, dfy;
      nxt = it[j];
      tx  = (it[j].yx << (B + 1)) + (it[j].k << (2 * B));
      ty  = (it[j].yy << (B + 1)) + (it[j].k << (2 * B));
      dfx = {1'b0, it[j].ex} - {1'b0, tx};
      dfy = {1'b0, it[j].ey} - {1'b0, ty};
      if (!dfx[WW]) begin
        nxt.ex    = dfx[WW-1:0];
        nxt.yx    = it[j].yx + (it[j].k << B);
        nxt.mx[B] = 1'b1;
      end
      if (!dfy[WW]) begin
        nxt.ey    = dfy[WW-1:0];
        nxt.yy    = it[j].yy + (it[j].k << B);
        nxt.my[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[j+1] <= nxt;
      end
    end
  end

  // last +/- (m + fraction), truncated toward zero, saturated.
  function automatic logic signed [CB-1:0] place(
    input logic signed [CB-1:0] last,
    input logic [MB-1:0]        m,
    input logic                 neg,
    input logic                 exact
  );
    logic signed [VW-1:0] le, me, v;
    le = {{(VW-CB){last[CB-1]}}, last};
    me = {{(VW-MB){1'b0}}, m};
    if (!neg) begin
      v = le + me;
      if (v < 0 && !exact) begin
        v = v + VW'(1);
      end
    end else begin
      v = le - me;
      if (!exact && v >= VW'(1)) begin
        v = v - VW'(1);
      end
    end
    if (v > MAXV) begin
      v = MAXV;
    end else if (v < MINV) begin
      v = MINV;
    end
    return v[CB-1:0];
  endfunction

  always_comb begin
    new_x_next = place(it[MB].lx, it[MB].mx, it[MB].negx, it[MB].ex == '0);
    new_y_next = place(it[MB].ly, it[MB].my, it[MB].negy, it[MB].ey == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_x <= new_x_next;
      new_y <= new_y_next;
    end
  end

`include "point_step_along_segment_top_assert.svh"

  `PSS_ASSERT_NXT(a_enter, in_ch.valid && in_ch.ready, vld[0], "accepted transaction lost")
  `PSS_ASSERT_IMP(a_len_nonzero, vld[2], p3.s != '0, "zero squared length in pipeline")
  `PSS_ASSERT_NXT(a_hold, !en, $stable(vld), "pipeline moved during stall")

endmodule
